### hdl/xa_sector_subsong_tracker_defines.svh
// assertion macros for the subsong tracker
`ifndef XA_SECTOR_SUBSONG_TRACKER_DEFINES_SVH
`define XA_SECTOR_SUBSONG_TRACKER_DEFINES_SVH

`ifndef SYNTH
`define XSST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define XSST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XSST_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define XSST_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

### hdl/xsst_pkg.sv
`default_nettype none
package xsst_pkg;

  localparam int CHANNELS = 32;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int INFO_W = 32;
  localparam int CNT_W = 20;
  localparam int OFS_W = 32;
  localparam int ENT_W = INFO_W + CNT_W;

  localparam logic [INFO_W-1:0] INFO_MASK = 32'hFFFF00FF;
  localparam logic [OFS_W-1:0] SECTOR_BYTES = 32'h00000930;
  localparam logic [OFS_W-1:0] NONE_YET = 32'hFFFFFFFF;
  localparam logic [CNT_W-1:0] CNT_MAX = 20'hFFFFF;

  localparam logic [7:0] SM_DATA = 8'h08;
  localparam logic [7:0] SM_AUDIO = 8'h04;
  localparam logic [7:0] SM_VIDEO = 8'h02;
  localparam logic [7:0] SM_EOF = 8'h80;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_OK   = 2'd1,
    ST_CHAN = 2'd2,
    ST_NONE = 2'd3
  } status_t;

  typedef enum logic {
    CFG_TARGET = 1'b0,
    CFG_START  = 1'b1
  } cfg_index_t;

endpackage
`default_nettype wire

### hdl/xa_sector_subsong_tracker.sv
// Sector subsong tracker.
// Input: one raw sector subheader word per item on sector_info, with is_last
// marking the final sector of a file. An item is taken at a clock edge where
// start is high and busy is low. busy is high through reset and goes low once
// reset is released, then stays low: a new sector can be taken in every cycle.
// Output: one result per item, shown for one cycle with done high. The item is
// first captured in stage 1 (s1_valid, s1_info), then the result is registered
// into done and the outputs (status 0 while running, final status on the last
// sector). The receiver cannot stall; results are never held back.
// Throughput is one item per cycle. Per-channel state lives in a 32-entry
// memory with registered read; the read is issued when an item is taken, the
// update is written back in the following cycle, and a forwarding register covers
// two sectors of the same channel in consecutive cycles.
// Configuration: cfg_valid/cfg_ready write channel (ready always high once
// out of reset), index 0 target song, index 1 base offset. Writing the
// base offset also reloads the running sector offset.
// Reset clears the channel table through per-entry valid bits, the counters
// and the error flag, and sets target song 1 and base offset 0. The same
// clear happens after each last sector, with the offset reloaded.
`default_nettype none
module xa_sector_subsong_tracker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [xsst_pkg::INFO_W-1:0] sector_info,
  input  wire logic                        is_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_index,
  input  wire logic [xsst_pkg::OFS_W-1:0]  cfg_data,
  output logic                             done,
  output logic      [xsst_pkg::CNT_W-1:0]  subsong_count,
  output logic      [xsst_pkg::OFS_W-1:0]  first_ofs,
  output logic      [xsst_pkg::OFS_W-1:0]  byte_total,
  output logic      [1:0]                  status
);
  import xsst_pkg::*;

  `include "xa_sector_subsong_tracker_defines.svh"

  // configuration
  logic [CNT_W-1:0] tgt_song;
  logic [OFS_W-1:0] base_ofs;

  // run counters
  logic [CNT_W-1:0] found_count;
  logic [OFS_W-1:0] first_target_offset;
  logic [CNT_W-1:0] target_sector_count;
  logic [OFS_W-1:0] sector_offset;
  logic             error_seen;

  // entry valid bits
  logic [CHANNELS-1:0] ent_valid;

  // stage 1
  logic              s1_valid;
  logic [INFO_W-1:0] s1_info;
  logic              s1_last;

  // forwarding of the last write
  logic              fwd_valid;
  logic [CH_W-1:0]   fwd_chan;
  logic [ENT_W-1:0]  fwd_data;

  logic              accept;
  logic              cfg_we;
  logic [ENT_W-1:0]  ram_rdata;
  logic [ENT_W-1:0]  ram_wdata;

  logic [7:0]        chan;
  logic [7:0]        submode;
  logic [CH_W-1:0]   idx;
  logic              in_range;
  logic              audio_ok;
  logic              upd;
  logic [ENT_W-1:0]  old_ent;
  logic [INFO_W-1:0] masked;
  logic              changed;
  logic [CNT_W-1:0]  found_next;
  logic [CNT_W-1:0]  sub_next;
  logic [CNT_W-1:0]  target;
  logic              hit;
  logic [OFS_W-1:0]  first_next;
  logic [CNT_W-1:0]  tcount_next;
  logic              error_next;
  status_t           status_next;
  logic [OFS_W-1:0]  size_next;

  assign accept = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_we = cfg_valid && cfg_ready;

  xsst_ram #(
    .WIDTH(ENT_W),
    .DEPTH(CHANNELS)
  ) u_chan_ram (
    .clk  (clk),
    .we   (s1_valid && upd),
    .waddr(idx),
    .wdata(ram_wdata),
    .raddr(sector_info[16 +: CH_W]),
    .rdata(ram_rdata)
  );

  always_comb begin
    chan = s1_info[23:16];
    submode = s1_info[15:8];
    idx = chan[CH_W-1:0];
    in_range = ({1'b0, chan} < 9'(CHANNELS));
    audio_ok = ((submode & SM_DATA) == 8'd0) && ((submode & SM_AUDIO) != 8'd0)
               && ((submode & SM_VIDEO) == 8'd0);
    upd = in_range && audio_ok;

    if (fwd_valid && (fwd_chan == idx)) begin
      old_ent = fwd_data;
    end else if (ent_valid[idx]) begin
      old_ent = ram_rdata;
    end else begin
      old_ent = '0;
    end

    masked = s1_info & INFO_MASK;
    changed = (old_ent[ENT_W-1 -: INFO_W] != masked);
    found_next = found_count;
    if (upd && changed && (found_count != CNT_MAX)) begin
      found_next = found_count + CNT_W'(1);
    end
    sub_next = changed ? found_next : old_ent[CNT_W-1:0];
    target = (tgt_song == '0) ? CNT_W'(1) : tgt_song;
    hit = upd && (sub_next == target);

    first_next = first_target_offset;
    tcount_next = target_sector_count;
    if (hit) begin
      if (first_target_offset == NONE_YET) begin
        first_next = sector_offset;
      end
      if (target_sector_count != CNT_MAX) begin
        tcount_next = target_sector_count + CNT_W'(1);
      end
    end

    if ((submode & SM_EOF) != 8'd0) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {masked, sub_next};
    end

    error_next = error_seen || !in_range;
    if (!s1_last) begin
      status_next = ST_RUN;
    end else if (error_next) begin
      status_next = ST_CHAN;
    end else if ((found_next == '0) || (target > found_next) || (tcount_next == '0)) begin
      status_next = ST_NONE;
    end else begin
      status_next = ST_OK;
    end

    size_next = OFS_W'(tcount_next) * SECTOR_BYTES;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      tgt_song <= CNT_W'(1);
      base_ofs <= '0;
      sector_offset <= '0;
      found_count <= '0;
      first_target_offset <= NONE_YET;
      target_sector_count <= '0;
      error_seen <= 1'b0;
      ent_valid <= '0;
      s1_valid <= 1'b0;
      fwd_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      s1_valid <= accept;
      done <= s1_valid;

      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_TARGET: tgt_song <= cfg_data[CNT_W-1:0];
          CFG_START: begin
            base_ofs <= cfg_data;
            sector_offset <= cfg_data;
          end
          default: ;
        endcase
      end

      if (s1_valid) begin
        if (s1_last) begin
          sector_offset <= base_ofs;
          found_count <= '0;
          first_target_offset <= NONE_YET;
          target_sector_count <= '0;
          error_seen <= 1'b0;
          ent_valid <= '0;
          fwd_valid <= 1'b0;
        end else begin
          sector_offset <= sector_offset + SECTOR_BYTES;
          found_count <= found_next;
          first_target_offset <= first_next;
          target_sector_count <= tcount_next;
          error_seen <= error_next;
          if (upd) begin
            ent_valid[idx] <= 1'b1;
          end
          fwd_valid <= upd;
        end
      end else begin
        fwd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= sector_info;
      s1_last <= is_last;
    end
    fwd_chan <= idx;
    fwd_data <= ram_wdata;
    if (s1_valid) begin
      subsong_count <= found_next;
      first_ofs <= first_next;
      byte_total <= size_next;
      status <= status_next;
    end
  end

  `XSST_ASSERT_NXT(a_result_follows, clk, rst, s1_valid, done, "item produced no result")
  `XSST_ASSERT_IMP(a_final_status, clk, rst, done && (status != ST_RUN), $past(s1_last), "final status on a running item")
  `XSST_ASSERT_IMP(a_fwd_source, clk, rst, fwd_valid, $past(s1_valid) && !$past(s1_last), "forwarding without a write")

endmodule
`default_nettype wire

### hdl/xsst_ram.sv
`default_nettype none
module xsst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/xsst_checker.sv
`timescale 1ns / 1ps
module xsst_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [xsst_pkg::INFO_W-1:0] sector_info,
  input  logic                        is_last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [xsst_pkg::OFS_W-1:0]  cfg_data,
  input  logic                        done,
  input  logic [xsst_pkg::CNT_W-1:0]  subsong_count,
  input  logic [xsst_pkg::OFS_W-1:0]  first_ofs,
  input  logic [xsst_pkg::OFS_W-1:0]  byte_total,
  input  logic [1:0]                  status,
  output int                          errors,
  output int                          pending
);
  import xsst_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [OFS_W-1:0] first;
    logic [OFS_W-1:0] size;
    logic [1:0]       st;
  } sector_report_t;

  sector_report_t expected_reports[$];

  logic [INFO_W-1:0] chan_word [CHANNELS];
  logic [CNT_W-1:0]  chan_song [CHANNELS];
  logic [CNT_W-1:0]  songs_found;
  logic [OFS_W-1:0]  first_hit_ofs;
  logic [CNT_W-1:0]  hit_sectors;
  logic [OFS_W-1:0]  cur_ofs;
  logic              chan_fault;
  logic [CNT_W-1:0]  target_reg;
  logic [OFS_W-1:0]  start_reg;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic clear_tracking();
    for (int i = 0; i < CHANNELS; i++) begin
      chan_word[i] = '0;
      chan_song[i] = '0;
    end
    songs_found = '0;
    first_hit_ofs = NONE_YET;
    hit_sectors = '0;
    cur_ofs = start_reg;
    chan_fault = 1'b0;
  endtask

  task automatic track_sector(input logic [INFO_W-1:0] info, input logic last,
                              output sector_report_t rep);
    logic [7:0]        chan;
    logic [7:0]        sm;
    logic [CNT_W-1:0]  target;
    logic [INFO_W-1:0] masked;
    chan = info[23:16];
    sm = info[15:8];
    target = (target_reg == '0) ? CNT_W'(1) : target_reg;
    if (chan >= CHANNELS) begin
      chan_fault = 1'b1;
    end else if ((sm & SM_DATA) == 8'h00 && (sm & SM_AUDIO) != 8'h00 &&
                 (sm & SM_VIDEO) == 8'h00) begin
      masked = info & INFO_MASK;
      if (chan_word[chan] != masked) begin
        if (songs_found != CNT_MAX) songs_found++;
        chan_word[chan] = masked;
        chan_song[chan] = songs_found;
      end
      if (chan_song[chan] == target) begin
        if (first_hit_ofs == NONE_YET) first_hit_ofs = cur_ofs;
        if (hit_sectors != CNT_MAX) hit_sectors++;
      end
      if ((sm & SM_EOF) != 8'h00) begin
        chan_word[chan] = '0;
        chan_song[chan] = '0;
      end
    end
    cur_ofs += SECTOR_BYTES;
    rep.count = songs_found;
    rep.first = first_hit_ofs;
    rep.size = OFS_W'(hit_sectors) * SECTOR_BYTES;
    rep.st = ST_RUN;
    if (last) begin
      if (chan_fault) rep.st = ST_CHAN;
      else if (songs_found == '0 || target > songs_found || hit_sectors == '0) rep.st = ST_NONE;
      else rep.st = ST_OK;
      clear_tracking();
    end
  endtask

  always @(posedge clk) begin : watch
    sector_report_t rep;
    if (rst) begin
      target_reg = CNT_W'(1);
      start_reg = '0;
      clear_tracking();
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_START) begin
          start_reg = cfg_data;
          cur_ofs = cfg_data;
        end else begin
          target_reg = cfg_data[CNT_W-1:0];
        end
      end
      if (start && !busy) begin
        track_sector(sector_info, is_last, rep);
        expected_reports.push_back(rep);
      end
      if (done) begin
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("result with no sector pending, count %0d status %0d",
                                    subsong_count, status));
        end else begin
          rep = expected_reports.pop_front();
          if (subsong_count !== rep.count)
            report_mismatch($sformatf("subsong_count %0d, expected %0d",
                                      subsong_count, rep.count));
          if (first_ofs !== rep.first)
            report_mismatch($sformatf("first_ofs %h, expected %h", first_ofs, rep.first));
          if (byte_total !== rep.size)
            report_mismatch($sformatf("byte_total %0d, expected %0d", byte_total, rep.size));
          if (status !== rep.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, rep.st));
        end
      end
    end
    pending <= expected_reports.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import xsst_pkg::*;

  localparam int NUM_ITEMS = 1450;
  localparam int STALL_LIMIT = 400;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [INFO_W-1:0] sector_info = '0;
  logic              is_last = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = CFG_TARGET;
  logic [OFS_W-1:0]  cfg_data = '0;
  logic              done;
  logic [CNT_W-1:0]  subsong_count;
  logic [OFS_W-1:0]  first_ofs;
  logic [OFS_W-1:0]  byte_total;
  logic [1:0]        status;

  int errors;
  int pending;
  int items_sent = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;

  always #4 clk = ~clk;

  xa_sector_subsong_tracker i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sector_info   (sector_info),
    .is_last       (is_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .subsong_count (subsong_count),
    .first_ofs     (first_ofs),
    .byte_total    (byte_total),
    .status        (status)
  );

  xsst_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sector_info   (sector_info),
    .is_last       (is_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .subsong_count (subsong_count),
    .first_ofs     (first_ofs),
    .byte_total    (byte_total),
    .status        (status),
    .errors        (errors),
    .pending       (pending)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic send_sector(input logic [INFO_W-1:0] info, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    sector_info <= info;
    is_last <= last;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // wait until every sector has reported back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [OFS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_file(input bit closes);
    logic [7:0]        chans [4];
    logic [INFO_W-1:0] words [4];
    logic [7:0]        sm;
    logic [INFO_W-1:0] info;
    int nch;
    int len;
    int k;
    int r;
    nch = $urandom_range(1, 4);
    for (int i = 0; i < nch; i++) begin
      chans[i] = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(32, 255))
                                              : 8'($urandom_range(0, 31));
      words[i] = {8'($urandom_range(0, 3)), chans[i], 8'h00, 8'($urandom_range(0, 3))};
    end
    len = $urandom_range(3, 30);
    for (int s = 0; s < len; s++) begin
      k = $urandom_range(0, nch - 1);
      r = $urandom_range(0, 99);
      // new header word on this channel
      if (r < 15)
        words[k] = {8'($urandom_range(0, 3)), chans[k], 8'h00, 8'($urandom_range(0, 3))};
      if (r >= 92) sm = 8'($urandom);
      else sm = SM_AUDIO | (8'($urandom) & 8'h71) | ((r < 6) ? SM_EOF : 8'h00);
      info = words[k] | {16'h0000, sm, 8'h00};
      if (r == 99) info = $urandom;
      else if (r == 98) info = {16'h0000, sm, 8'h00};
      send_sector(info, closes && s == len - 1);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] tgt;
    logic [OFS_W-1:0] ofs;
    int files;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero target means one, offset wraps during the file
    write_reg(CFG_TARGET, 32'h0);
    write_reg(CFG_START, 32'hFFFF_E000);
    send_sector(32'h0000_0400, 1'b0);
    send_sector(32'h0100_0401, 1'b0);
    send_sector(32'h0100_0C01, 1'b0);
    send_sector(32'h0100_0601, 1'b0);
    send_sector(32'h0100_0001, 1'b0);
    send_sector(32'h0201_0405, 1'b0);
    send_sector(32'h0100_8401, 1'b0);
    send_sector(32'h0100_0401, 1'b0);
    send_sector(32'hFF1F_F5FF, 1'b0);
    send_sector(32'h0100_0401, 1'b1);
    // channel out of range
    send_sector(32'h0120_0401, 1'b0);
    send_sector(32'hFFFF_FFFF, 1'b0);
    send_sector(32'h0100_0401, 1'b1);
    // nothing found
    send_sector(32'h0000_0400, 1'b1);
    settle();

    write_reg(CFG_TARGET, {12'hFFF, CNT_MAX});
    write_reg(CFG_START, 32'h0);
    send_sector(32'h0003_0412, 1'b0);
    send_sector(32'h0004_0413, 1'b1);
    settle();

    write_reg(CFG_TARGET, 32'h2);
    send_sector(32'h0100_0401, 1'b0);
    send_sector(32'h0100_0401, 1'b1);
    settle();

    while (items_sent < NUM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: tgt = '0;
          1: tgt = CNT_MAX;
          2: tgt = CNT_W'($urandom_range(5, 1048575));
          default: tgt = CNT_W'($urandom_range(1, 4));
        endcase
        write_reg(CFG_TARGET, {12'($urandom), tgt});
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 5))
          0: ofs = '0;
          1: ofs = 32'hFFFF_FFFF;
          2: ofs = 32'hFFFF_FFFF - $urandom_range(0, 40000);
          default: ofs = $urandom;
        endcase
        write_reg(CFG_START, ofs);
      end
      files = $urandom_range(1, 3);
      for (int f = 0; f < files; f++)
        send_file(!(f == files - 1 && $urandom_range(0, 4) == 0));
      settle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/xsst_pkg.sv
hdl/xsst_ram.sv
hdl/xa_sector_subsong_tracker.sv
tb/xsst_checker.sv
tb/tb.sv
